// ----- sv/fvn_pkg.sv -----
package fvn_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_OCTAVES = 2'd1;
  localparam logic [1:0] REG_PERSIST = 2'd2;

  // hash mixing constants
  localparam logic [63:0] K_CELL_X = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] K_CELL_Y = 64'hC6A4A7935BD1E995;
  localparam logic [63:0] K_MIX_A = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] K_MIX_B = 64'hC4CEB9FE1A85EC53;

  // 1.0 in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  // 3.0 in Q2.16, the constant term of the smoothstep factor 3 - 2t
  localparam logic [17:0] THREE_Q16 = 18'h30000;

  // per-octave settings handed to every cell
  typedef struct packed {
    logic        act;
    logic [63:0] seed;
    logic [15:0] pers;
  } cell_cfg_t;

  // low half of a 64x64 product: 32x32 low partial
  function automatic logic [63:0] mul_lo(input logic [31:0] a, input logic [31:0] k);
    logic [63:0] p;
    p = 64'(a) * 64'(k);
    return p;
  endfunction

  // low half of a 64x64 product: cross partials, only their low 32 bits matter
  function automatic logic [31:0] mul_mid(input logic [63:0] a, input logic [63:0] k);
    logic [31:0] m;
    m = a[31:0] * k[63:32] + a[63:32] * k[31:0];
    return m;
  endfunction

endpackage

// ----- sv/fractal_value_noise_2d.sv -----
// channel  | dir | width | contents
// s_axis   | in  | 64    | coord_x [31:0], coord_y [63:32], signed Q16.16
// m_axis   | out | 24    | noise_value [16:0], Q1.16, upper bits zero
// cfg      | in  | 64    | write port: 0 seed, 1 octave count, 2 persistence
//
// one point per cycle while the pipeline is not held; points pass through the
// row of octave cells (nine stages each) and the 18-stage divider
// reset clears the pipeline valid bits and loads the default configuration
// when the output register and the skid stage are both full the whole
// pipeline holds and s_axis_tready drops
module fractal_value_noise_2d import fvn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES     = 8,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // coord_x [31:0], coord_y [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // noise_value [16:0], zero fill
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned CW     = COORD_FRAC_BITS + 32;
  localparam int unsigned TOT_W  = 33 + $clog2(MAX_OCTAVES + 1);
  localparam int unsigned ASUM_W = 18 + $clog2(MAX_OCTAVES + 1);

  // configuration registers
  logic [63:0] seed_q;
  logic [3:0]  oct_q;
  logic [15:0] pers_q;
  logic [4:0]  n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= 4'd4;
      pers_q <= 16'h8000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEED:    seed_q <= cfg_wdata_i;
        REG_OCTAVES: oct_q  <= cfg_wdata_i[3:0];
        REG_PERSIST: pers_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // clamp octave count to 1..MAX_OCTAVES
  always_comb begin
    if (oct_q == 4'd0) n_eff = 5'd1;
    else if ({1'b0, oct_q} > 5'(MAX_OCTAVES)) n_eff = 5'(MAX_OCTAVES);
    else n_eff = {1'b0, oct_q};
  end

  // pipeline advance and output skid
  logic        en;
  logic        in_v_q;
  logic [CW-1:0] in_px_q, in_py_q;
  logic        out_v_q, skid_v_q;
  logic [16:0] out_q, skid_q;
  logic        fin_v;
  logic [16:0] fin_q;

  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else if (en) in_v_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_px_q <= {{COORD_FRAC_BITS{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
      in_py_q <= {{COORD_FRAC_BITS{s_axis_tdata[63]}}, s_axis_tdata[63:32]};
    end
  end

  // row of octave cells
  logic              ch_v   [0:MAX_OCTAVES];
  logic [CW-1:0]     ch_px  [0:MAX_OCTAVES];
  logic [CW-1:0]     ch_py  [0:MAX_OCTAVES];
  logic [16:0]       ch_amp [0:MAX_OCTAVES];
  logic [TOT_W-1:0]  ch_tot [0:MAX_OCTAVES];
  logic [ASUM_W-1:0] ch_as  [0:MAX_OCTAVES];

  assign ch_v[0]   = in_v_q;
  assign ch_px[0]  = in_px_q;
  assign ch_py[0]  = in_py_q;
  assign ch_amp[0] = ONE_Q16;
  assign ch_tot[0] = '0;
  assign ch_as[0]  = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    cell_cfg_t ccfg;
    assign ccfg.act  = 5'(i) < n_eff;
    assign ccfg.seed = seed_q;
    assign ccfg.pers = pers_q;

    fvn_cell #(
      .IDX    (i),
      .CFB    (COORD_FRAC_BITS),
      .TOT_W  (TOT_W),
      .ASUM_W (ASUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .cfg_i   (ccfg),
      .valid_i (ch_v[i]),
      .px_i    (ch_px[i]),
      .py_i    (ch_py[i]),
      .amp_i   (ch_amp[i]),
      .total_i (ch_tot[i]),
      .asum_i  (ch_as[i]),
      .valid_o (ch_v[i+1]),
      .px_o    (ch_px[i+1]),
      .py_o    (ch_py[i+1]),
      .amp_o   (ch_amp[i+1]),
      .total_o (ch_tot[i+1]),
      .asum_o  (ch_as[i+1])
    );
  end

  // normalize by the amplitude sum
  fvn_div #(
    .TOT_W  (TOT_W),
    .ASUM_W (ASUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ch_v[MAX_OCTAVES]),
    .total_i (ch_tot[MAX_OCTAVES]),
    .asum_i  (ch_as[MAX_OCTAVES]),
    .valid_o (fin_v),
    .quo_o   (fin_q)
  );

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (fin_v) begin
      if (!out_v_q || m_axis_tready) out_v_q <= 1'b1;
      else skid_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) out_q <= skid_q;
    end else if (fin_v) begin
      if (!out_v_q || m_axis_tready) out_q <= fin_q;
      else skid_q <= fin_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_q};

  // skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full with empty output");

  // a parked result moves out when the sink takes the current one
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && m_axis_tready) |=> (out_v_q && !skid_v_q))
    else $error("skid did not drain");

  // result never above 1.0
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q <= ONE_Q16)) else $error("noise above 1.0");

  // octave count in use stays in range
  a_octaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_eff >= 5'd1) && (n_eff <= 5'(MAX_OCTAVES))) else $error("octave count out of range");

endmodule

// ----- sv/fvn_cell.sv -----
module fvn_cell import fvn_pkg::*; #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned CFB    = 16,
  parameter int unsigned TOT_W  = 36,
  parameter int unsigned ASUM_W = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cell_cfg_t           cfg_i,
  input  logic                valid_i,
  input  logic [CFB+31:0]     px_i,
  input  logic [CFB+31:0]     py_i,
  input  logic [16:0]         amp_i,
  input  logic [TOT_W-1:0]    total_i,
  input  logic [ASUM_W-1:0]   asum_i,
  output logic                valid_o,
  output logic [CFB+31:0]     px_o,
  output logic [CFB+31:0]     py_o,
  output logic [16:0]         amp_o,
  output logic [TOT_W-1:0]    total_o,
  output logic [ASUM_W-1:0]   asum_o
);

  localparam int unsigned CW = CFB + 32;
  localparam int unsigned NS = 8;

  // item data riding along the stages
  logic             v_q [1:NS];
  logic [CW-1:0]    px_q [1:NS];
  logic [CW-1:0]    py_q [1:NS];
  logic [16:0]      amp_q [1:NS];
  logic [TOT_W-1:0] tot_q [1:NS];
  logic [ASUM_W-1:0] as_q [1:NS];

  // stage 1: lattice products and smoothstep squares
  logic [63:0] xlo_q [2];
  logic [31:0] xmid_q [2];
  logic [63:0] ylo_q [2];
  logic [31:0] ymid_q [2];
  logic [31:0] ttx_q, tty_q;
  logic [17:0] wx_q, wy_q;
  // stage 2
  logic [63:0] xp_q [2];
  logic [63:0] yp_q [2];
  logic [15:0] sx_q [2:6];
  logic [15:0] sy_q [2:7];
  // stages 3..6: corner hashes
  logic [63:0] alo_q [4];
  logic [31:0] amid_q [4];
  logic [63:0] hb_q [4];
  logic [63:0] blo_q [4];
  logic [31:0] bmid_q [4];
  logic [15:0] n_q [4];
  // stages 7..8: blend
  logic [32:0] r0_q, r1_q;
  logic [15:0] val_q;

  logic [31:0] x0, y0, x1, y1;
  logic [23:0] fx24, fy24;
  logic [15:0] tx, ty;
  logic [63:0] xs [2];
  logic [63:0] ys [2];
  logic [49:0] epx, epy;
  logic [63:0] seed_c;
  logic [63:0] h0 [4];
  logic [63:0] m0 [4];
  logic [63:0] m1 [4];
  logic [63:0] h3 [4];
  logic [16:0] wsx, wsy;
  logic [49:0] vsum;
  logic [32:0] vamp, pamp;

  // cell index and fraction of the scaled coordinates
  always_comb begin
    x0   = px_i[CW-1:CFB];
    y0   = py_i[CW-1:CFB];
    x1   = x0 + 32'd1;
    y1   = y0 + 32'd1;
    fx24 = 24'(px_i[CFB-1:0]) << (24 - CFB);
    fy24 = 24'(py_i[CFB-1:0]) << (24 - CFB);
    tx   = fx24[23:8];
    ty   = fy24[23:8];
    xs[0] = {{32{x0[31]}}, x0};
    xs[1] = {{32{x1[31]}}, x1};
    ys[0] = {{32{y0[31]}}, y0};
    ys[1] = {{32{y1[31]}}, y1};
  end

  // smoothstep products
  assign epx = 50'(ttx_q) * 50'(wx_q);
  assign epy = 50'(tty_q) * 50'(wy_q);

  // corner hash front and back mixing
  assign seed_c = cfg_i.seed + 64'(IDX);
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h0[c] = seed_c ^ xp_q[c % 2] ^ yp_q[c / 2];
      m0[c] = h0[c] ^ (h0[c] >> 33);
      m1[c] = hb_q[c] ^ (hb_q[c] >> 33);
      h3[c] = blo_q[c] + {bmid_q[c], 32'd0};
    end
  end

  // blend weights and final blend
  assign wsx  = ONE_Q16 - {1'b0, sx_q[6]};
  assign wsy  = ONE_Q16 - {1'b0, sy_q[7]};
  assign vsum = 50'(r0_q) * 50'(wsy) + 50'(r1_q) * 50'(sy_q[7]);

  // octave weight and next amplitude
  assign vamp = 33'(val_q) * 33'(amp_q[NS]);
  assign pamp = 33'(amp_q[NS]) * 33'(cfg_i.pers);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= NS; s++) v_q[s] <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q[1] <= valid_i;
      for (int s = 2; s <= NS; s++) v_q[s] <= v_q[s-1];
      valid_o <= v_q[NS];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q[1]  <= px_i;
      py_q[1]  <= py_i;
      amp_q[1] <= amp_i;
      tot_q[1] <= total_i;
      as_q[1]  <= asum_i;
      for (int s = 2; s <= NS; s++) begin
        px_q[s]  <= px_q[s-1];
        py_q[s]  <= py_q[s-1];
        amp_q[s] <= amp_q[s-1];
        tot_q[s] <= tot_q[s-1];
        as_q[s]  <= as_q[s-1];
      end

      // stage 1
      for (int j = 0; j < 2; j++) begin
        xlo_q[j]  <= mul_lo(xs[j][31:0], K_CELL_X[31:0]);
        xmid_q[j] <= mul_mid(xs[j], K_CELL_X);
        ylo_q[j]  <= mul_lo(ys[j][31:0], K_CELL_Y[31:0]);
        ymid_q[j] <= mul_mid(ys[j], K_CELL_Y);
      end
      ttx_q <= 32'(tx) * 32'(tx);
      tty_q <= 32'(ty) * 32'(ty);
      wx_q  <= THREE_Q16 - {1'b0, tx, 1'b0};
      wy_q  <= THREE_Q16 - {1'b0, ty, 1'b0};

      // stage 2
      for (int j = 0; j < 2; j++) begin
        xp_q[j] <= xlo_q[j] + {xmid_q[j], 32'd0};
        yp_q[j] <= ylo_q[j] + {ymid_q[j], 32'd0};
      end
      sx_q[2] <= epx[47:32];
      sy_q[2] <= epy[47:32];
      for (int s = 3; s <= 6; s++) sx_q[s] <= sx_q[s-1];
      for (int s = 3; s <= 7; s++) sy_q[s] <= sy_q[s-1];

      for (int c = 0; c < 4; c++) begin
        // stage 3
        alo_q[c]  <= mul_lo(m0[c][31:0], K_MIX_A[31:0]);
        amid_q[c] <= mul_mid(m0[c], K_MIX_A);
        // stage 4
        hb_q[c]   <= alo_q[c] + {amid_q[c], 32'd0};
        // stage 5
        blo_q[c]  <= mul_lo(m1[c][31:0], K_MIX_B[31:0]);
        bmid_q[c] <= mul_mid(m1[c], K_MIX_B);
        // stage 6: top bits of the low word after the last xor-shift
        n_q[c]    <= h3[c][31:16] ^ {1'b0, h3[c][63:49]};
      end

      // stage 7: row blends
      r0_q <= 33'(n_q[0]) * 33'(wsx) + 33'(n_q[1]) * 33'(sx_q[6]);
      r1_q <= 33'(n_q[2]) * 33'(wsx) + 33'(n_q[3]) * 33'(sx_q[6]);

      // stage 8: column blend
      val_q <= vsum[47:32];

      // hand off to the next octave
      px_o  <= {px_q[NS][CW-2:0], 1'b0};
      py_o  <= {py_q[NS][CW-2:0], 1'b0};
      amp_o <= pamp[32:16];
      if (cfg_i.act) begin
        total_o <= tot_q[NS] + TOT_W'(vamp);
        asum_o  <= as_q[NS] + ASUM_W'(amp_q[NS]);
      end else begin
        total_o <= tot_q[NS];
        asum_o  <= as_q[NS];
      end
    end
  end

endmodule

// ----- sv/fvn_div.sv -----
module fvn_div import fvn_pkg::*; #(
  parameter int unsigned TOT_W  = 36,
  parameter int unsigned ASUM_W = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [TOT_W-1:0]  total_i,
  input  logic [ASUM_W-1:0] asum_i,
  output logic              valid_o,
  output logic [16:0]       quo_o
);

  localparam int unsigned QB = 17;
  localparam int unsigned DW = ASUM_W + QB;

  logic              v_q [0:QB];
  logic [DW-1:0]     rem_q [0:QB];
  logic [ASUM_W-1:0] d_q [0:QB];
  logic [QB-1:0]     q_q [0:QB];
  logic              sat_q [0:QB];

  logic [DW-1:0] sub [1:QB];

  // shifted divisor for each quotient bit
  always_comb begin
    for (int k = 1; k <= QB; k++) sub[k] = DW'(d_q[k-1]) << (QB - k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= QB; k++) v_q[k] <= v_q[k-1];
    end
  end

  // one restoring step per stage, most significant quotient bit first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(total_i);
      d_q[0]   <= asum_i;
      q_q[0]   <= '0;
      sat_q[0] <= DW'(total_i) >= {asum_i, {QB{1'b0}}};
      for (int k = 1; k <= QB; k++) begin
        d_q[k]   <= d_q[k-1];
        sat_q[k] <= sat_q[k-1];
        if (rem_q[k-1] >= sub[k]) begin
          rem_q[k] <= rem_q[k-1] - sub[k];
          q_q[k]   <= q_q[k-1] | (QB'(1) << (QB - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          q_q[k]   <= q_q[k-1];
        end
      end
    end
  end

  assign valid_o = v_q[QB];
  assign quo_o   = (sat_q[QB] || q_q[QB] > ONE_Q16) ? ONE_Q16 : q_q[QB];

endmodule
